// ----- src/mfcrc_pkg.sv -----
package mfcrc_pkg;

    localparam int unsigned CRC_W  = 16;
    localparam int unsigned BYTE_W = 8;

    typedef enum logic [1:0] {
        FUNC_INIT,
        FUNC_HEADER,
        FUNC_DATA,
        FUNC_TRAILER
    } t_func;

    typedef enum logic [1:0] {
        CHK_INIT,
        CHK_PENDING,
        CHK_PASSED,
        CHK_FAILED
    } t_check;

    typedef enum logic [2:0] {
        STS_OK,
        STS_CRC_ERR,
        STS_WRONG_SEQ,
        STS_REPEATED,
        STS_SOME_LOST
    } t_status;

    typedef enum logic [1:0] {
        TRL_COUNTER,
        TRL_SPARE,
        TRL_CRC_LO,
        TRL_CRC_HI
    } t_trl_slot;

    typedef enum logic {
        REG_CRC_POLY,
        REG_CRC_INIT
    } t_reg_index;

    localparam logic [CRC_W-1:0]  CRC_POLY_RESET = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_INIT_RESET = 16'hFFFF;
    localparam logic [BYTE_W-1:0] CNT_MAX        = 8'hFF;

    typedef struct packed {
        t_func              func;
        logic [BYTE_W-1:0]  data_byte;
        logic               frame_first;
        logic               frame_last;
        logic [BYTE_W-1:0]  multiplexor;
    } t_item;

    typedef struct packed {
        t_status            status;
        t_check             check_result;
        logic [CRC_W-1:0]   computed_crc;
    } t_result;

    // msb-first crc over one byte, one shift per bit
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] v;
        v = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (v[CRC_W-1]) begin
                v = {v[CRC_W-2:0], 1'b0} ^ poly;
            end else begin
                v = {v[CRC_W-2:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ----- src/mfcrc_in_stage.sv -----
module mfcrc_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  mfcrc_pkg::t_item     i_item,
    input  logic                 i_out_free,
    output logic                 o_in_stall,
    output logic                 o_go,
    output mfcrc_pkg::t_item     o_item
);

    logic             r_valid;
    logic             n_valid;
    mfcrc_pkg::t_item r_item;
    logic             w_accept;
    logic             w_makes_result;

    // only a closing trailer byte needs room in the result register
    assign w_makes_result = (r_item.func == mfcrc_pkg::FUNC_TRAILER) && r_item.frame_last;
    assign o_go           = r_valid && (!w_makes_result || i_out_free);
    assign o_in_stall     = r_valid && !o_go;
    assign w_accept       = i_in_valid && !o_in_stall;
    assign n_valid        = w_accept || (r_valid && !o_go);
    assign o_item         = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- src/mfcrc_check.sv -----
module mfcrc_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  mfcrc_pkg::t_reg_index          i_cfg_index,
    input  logic [mfcrc_pkg::CRC_W-1:0]    i_cfg_data,
    input  logic                           i_go,
    input  mfcrc_pkg::t_item               i_item,
    output logic                           o_res_valid,
    output mfcrc_pkg::t_result             o_result
);

    logic [mfcrc_pkg::CRC_W-1:0]  r_crc_poly;
    logic [mfcrc_pkg::CRC_W-1:0]  r_crc_init;

    mfcrc_pkg::t_check            r_state,         n_state;
    logic                         r_header_seen,   n_header_seen;
    logic [mfcrc_pkg::BYTE_W-1:0] r_data_count,    n_data_count;
    logic [mfcrc_pkg::CRC_W-1:0]  r_running_crc,   n_running_crc;
    logic                         r_data_frame_ok, n_data_frame_ok;
    logic [1:0]                   r_trl_index,     n_trl_index;
    logic [mfcrc_pkg::BYTE_W-1:0] r_trl_counter,   n_trl_counter;
    logic [mfcrc_pkg::CRC_W-1:0]  r_trl_crc,       n_trl_crc;
    logic [mfcrc_pkg::BYTE_W-1:0] r_last_counter,  n_last_counter;
    logic                         r_first_trailer, n_first_trailer;
    mfcrc_pkg::t_status           r_status,        n_status;

    logic [mfcrc_pkg::CRC_W-1:0]  w_crc_base;
    logic [mfcrc_pkg::CRC_W-1:0]  w_crc_next;
    logic [1:0]                   w_trl_index;
    logic [mfcrc_pkg::BYTE_W-1:0] w_trl_counter;
    logic [mfcrc_pkg::CRC_W-1:0]  w_trl_crc;
    logic                         w_mux_follows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_poly <= mfcrc_pkg::CRC_POLY_RESET;
            r_crc_init <= mfcrc_pkg::CRC_INIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mfcrc_pkg::REG_CRC_POLY: r_crc_poly <= i_cfg_data;
                mfcrc_pkg::REG_CRC_INIT: r_crc_init <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_crc_base = (i_item.func == mfcrc_pkg::FUNC_HEADER && i_item.frame_first) ?
                        r_crc_init : r_running_crc;
    assign w_crc_next = mfcrc_pkg::crc_byte(w_crc_base, i_item.data_byte, r_crc_poly);

    assign w_trl_index   = i_item.frame_first ? 2'd0 : r_trl_index;
    assign w_trl_counter = i_item.frame_first ? '0 : r_trl_counter;
    assign w_trl_crc     = i_item.frame_first ? '0 : r_trl_crc;

    assign w_mux_follows = ({1'b0, i_item.multiplexor} == ({1'b0, r_data_count} + 9'd1));

    // next state
    always_comb begin
        n_state         = r_state;
        n_header_seen   = r_header_seen;
        n_data_count    = r_data_count;
        n_running_crc   = r_running_crc;
        n_data_frame_ok = r_data_frame_ok;
        n_trl_index     = r_trl_index;
        n_trl_counter   = r_trl_counter;
        n_trl_crc       = r_trl_crc;
        n_last_counter  = r_last_counter;
        n_first_trailer = r_first_trailer;
        n_status        = r_status;
        if (i_go) begin
            case (i_item.func)
                mfcrc_pkg::FUNC_INIT: begin
                    n_header_seen   = 1'b0;
                    n_data_count    = '0;
                    n_running_crc   = '0;
                    n_data_frame_ok = 1'b0;
                    n_trl_index     = 2'd0;
                    n_state         = mfcrc_pkg::CHK_INIT;
                end
                mfcrc_pkg::FUNC_HEADER: begin
                    if (i_item.frame_first) begin
                        n_header_seen   = 1'b1;
                        n_data_count    = '0;
                        n_data_frame_ok = 1'b0;
                        n_trl_index     = 2'd0;
                        n_state         = mfcrc_pkg::CHK_PENDING;
                    end
                    n_running_crc = w_crc_next;
                end
                mfcrc_pkg::FUNC_DATA: begin
                    if (i_item.frame_first) begin
                        n_data_frame_ok = 1'b0;
                        if (r_state == mfcrc_pkg::CHK_PENDING) begin
                            if (!r_header_seen) begin
                                n_state = mfcrc_pkg::CHK_FAILED;
                            end else if (r_data_count != '0 && !w_mux_follows) begin
                                n_state = mfcrc_pkg::CHK_FAILED;
                            end else begin
                                n_data_frame_ok = 1'b1;
                                n_data_count    = i_item.multiplexor;
                            end
                        end
                    end
                    if (n_data_frame_ok) begin
                        n_running_crc = w_crc_next;
                    end
                end
                mfcrc_pkg::FUNC_TRAILER: begin
                    n_trl_counter = w_trl_counter;
                    n_trl_crc     = w_trl_crc;
                    case (mfcrc_pkg::t_trl_slot'(w_trl_index))
                        mfcrc_pkg::TRL_COUNTER: n_trl_counter = i_item.data_byte;
                        mfcrc_pkg::TRL_CRC_LO:  n_trl_crc = {w_trl_crc[15:8], i_item.data_byte};
                        mfcrc_pkg::TRL_CRC_HI:  n_trl_crc = {i_item.data_byte, w_trl_crc[7:0]};
                        default: ;
                    endcase
                    n_trl_index = w_trl_index + 2'd1;
                    if (i_item.frame_last) begin
                        if (r_state == mfcrc_pkg::CHK_PENDING) begin
                            if (!r_header_seen) begin
                                n_state = mfcrc_pkg::CHK_FAILED;
                            end else if (r_running_crc != n_trl_crc) begin
                                n_state  = mfcrc_pkg::CHK_FAILED;
                                n_status = mfcrc_pkg::STS_CRC_ERR;
                            end else if (r_first_trailer) begin
                                n_first_trailer = 1'b0;
                                n_state         = mfcrc_pkg::CHK_PASSED;
                                n_status        = mfcrc_pkg::STS_OK;
                            end else if (r_last_counter > n_trl_counter &&
                                         r_last_counter != mfcrc_pkg::CNT_MAX) begin
                                n_state  = mfcrc_pkg::CHK_FAILED;
                                n_status = mfcrc_pkg::STS_WRONG_SEQ;
                            end else if (r_last_counter == n_trl_counter) begin
                                n_state  = mfcrc_pkg::CHK_FAILED;
                                n_status = mfcrc_pkg::STS_REPEATED;
                            end else if (r_last_counter + 8'd1 != n_trl_counter) begin
                                n_state  = mfcrc_pkg::CHK_FAILED;
                                n_status = mfcrc_pkg::STS_SOME_LOST;
                            end else begin
                                n_state  = mfcrc_pkg::CHK_PASSED;
                                n_status = mfcrc_pkg::STS_OK;
                            end
                        end
                        n_last_counter = n_trl_counter;
                    end
                end
                default: ;
            endcase
        end
    end

    // result
    always_comb begin
        o_res_valid           = i_go && (i_item.func == mfcrc_pkg::FUNC_TRAILER) &&
                                i_item.frame_last;
        o_result.status       = n_status;
        o_result.check_result = n_state;
        o_result.computed_crc = r_running_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= mfcrc_pkg::CHK_INIT;
            r_header_seen   <= 1'b0;
            r_data_count    <= '0;
            r_running_crc   <= '0;
            r_data_frame_ok <= 1'b0;
            r_trl_index     <= 2'd0;
            r_trl_counter   <= '0;
            r_trl_crc       <= '0;
            r_last_counter  <= '0;
            r_first_trailer <= 1'b1;
            r_status        <= mfcrc_pkg::STS_OK;
        end else begin
            r_state         <= n_state;
            r_header_seen   <= n_header_seen;
            r_data_count    <= n_data_count;
            r_running_crc   <= n_running_crc;
            r_data_frame_ok <= n_data_frame_ok;
            r_trl_index     <= n_trl_index;
            r_trl_counter   <= n_trl_counter;
            r_trl_crc       <= n_trl_crc;
            r_last_counter  <= n_last_counter;
            r_first_trailer <= n_first_trailer;
            r_status        <= n_status;
        end
    end

endmodule

// ----- src/mfcrc_out_stage.sv -----
module mfcrc_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  mfcrc_pkg::t_result   i_result,
    input  logic                 i_out_stall,
    output logic                 o_free,
    output logic                 o_out_valid,
    output mfcrc_pkg::t_result   o_result
);

    logic               r_valid;
    logic               n_valid;
    mfcrc_pkg::t_result r_result;

    assign o_free      = !r_valid || !i_out_stall;
    assign n_valid     = i_load || (r_valid && i_out_stall);
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- src/e2e_multiframe_crc_sequence_checker_core.sv -----
// multi-frame end-to-end checker: msb-first crc-16 plus a trailer counter
//
// input channel: one byte per transfer on i_in_valid / o_in_stall, tagged
// by i_in_func (init, header, data, trailer) with first/last frame marks
// and the data frame multiplexor. output channel: one result per closing
// trailer byte on o_out_valid / i_out_stall with status, check state and
// the crc computed over header and accepted data bytes.
// config: i_cfg_valid / o_cfg_ready write channel, index 0 polynomial,
// index 1 crc start value; always ready, write only while idle.
//
// path: a byte enters the input register and is evaluated combinationally
// there; when it moves on, the check state registers update and a closing
// trailer byte's result is loaded into the result register.
// throughput: one byte per cycle unless a closing trailer byte waits on a
// held result; eight unrolled and/xor shift steps update the running crc.
// reset: clears both stages and the check state, loads polynomial 0x1021
// and start value 0xffff.
// stall: a held result stops the next closing trailer byte in the input
// register and the bytes behind it; earlier bytes flow while it waits.
module e2e_multiframe_crc_sequence_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_in_func,
    input  logic [7:0]  i_in_data_byte,
    input  logic        i_in_frame_first,
    input  logic        i_in_frame_last,
    input  logic [7:0]  i_in_multiplexor,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_out_status,
    output logic [1:0]  o_out_check_result,
    output logic [15:0] o_out_computed_crc,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    mfcrc_pkg::t_item   w_in_item;
    mfcrc_pkg::t_item   w_stage_item;
    mfcrc_pkg::t_result w_result;
    mfcrc_pkg::t_result w_out_result;
    logic               w_go;
    logic               w_out_free;
    logic               w_res_valid;

    assign o_cfg_ready = 1'b1;

    assign w_in_item.func        = mfcrc_pkg::t_func'(i_in_func);
    assign w_in_item.data_byte   = i_in_data_byte;
    assign w_in_item.frame_first = i_in_frame_first;
    assign w_in_item.frame_last  = i_in_frame_last;
    assign w_in_item.multiplexor = i_in_multiplexor;

    mfcrc_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (w_in_item),
        .i_out_free (w_out_free),
        .o_in_stall (o_in_stall),
        .o_go       (w_go),
        .o_item     (w_stage_item)
    );

    mfcrc_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (mfcrc_pkg::t_reg_index'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .i_go        (w_go),
        .i_item      (w_stage_item),
        .o_res_valid (w_res_valid),
        .o_result    (w_result)
    );

    mfcrc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_res_valid),
        .i_result    (w_result),
        .i_out_stall (i_out_stall),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .o_result    (w_out_result)
    );

    assign o_out_status       = w_out_result.status;
    assign o_out_check_result = w_out_result.check_result;
    assign o_out_computed_crc = w_out_result.computed_crc;

endmodule

// ----- src/mfcrc_checker.sv -----
module mfcrc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  o_out_status,
    input  logic [1:0]  o_out_check_result,
    input  logic [15:0] o_out_computed_crc
);

    // result register cleared by reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_status) &&
        $stable(o_out_check_result) && $stable(o_out_computed_crc))
        else $error("stalled result changed");

    // an empty result register never backs up the input
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_status <= 3'(mfcrc_pkg::STS_SOME_LOST))
        else $error("status code out of range");

endmodule

bind e2e_multiframe_crc_sequence_checker_core mfcrc_checker u_mfcrc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_out_status       (o_out_status),
    .o_out_check_result (o_out_check_result),
    .o_out_computed_crc (o_out_computed_crc)
);
